// ===== rtl/core/hppdma_pkg.sv =====
package hppdma_pkg;

   // item kinds on the request channel
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_REPLY = 2'd2,
      KIND_IDLE  = 2'd3
   } kind_type;

   // internal registers reached through the slot table
   typedef enum logic [3:0] {
      HREG_PAR  = 4'd0,
      HREG_PDR  = 4'd1,
      HREG_EMR  = 4'd2,
      HREG_ESR  = 4'd3,
      HREG_PCR  = 4'd4,
      HREG_PIR  = 4'd5,
      HREG_PARE = 4'd6,
      HREG_PDR2 = 4'd7,
      HREG_RES  = 4'd8
   } hreg_type;

   // byte lane of a slot
   typedef enum logic [1:0] {
      LANE_FULL = 2'd0,
      LANE_LOW  = 2'd1,
      LANE_HIGH = 2'd2
   } lane_type;

   // memory request codes
   typedef enum logic [2:0] {
      MEM_NONE       = 3'd0,
      MEM_READ_WORD  = 3'd1,
      MEM_READ_LONG  = 3'd2,
      MEM_WRITE_WORD = 3'd3,
      MEM_WRITE_LONG = 3'd4
   } mem_req_type;

   typedef struct packed {
      hreg_type hreg;
      lane_type lane;
   } slot_type;

   // control word bit positions
   localparam int unsigned CtlReset = 0;
   localparam int unsigned CtlMap   = 1;
   localparam int unsigned CtlEni   = 2;
   localparam int unsigned CtlDma   = 3;
   localparam int unsigned CtlAuto  = 4;
   localparam int unsigned CtlPdf   = 5;
   localparam int unsigned CtlPif   = 6;
   localparam int unsigned CtlDma32 = 8;
   localparam int unsigned CtlPort16 = 9;

   // control bits the host cannot write
   localparam logic [15:0] CtlHostKeep  = 16'h0060;
   localparam logic [15:0] CtlAfterReset = 16'h0001;
   localparam logic [15:0] EmrReset     = 16'hffff;
   localparam logic [15:0] ReadReserved = 16'hffff;
   localparam logic [23:0] AlignWord    = 24'hfffffe;
   localparam logic [23:0] AlignLong    = 24'hfffffc;

   function automatic slot_type mk(input hreg_type r, input lane_type l);
      slot_type s;
      s.hreg = r;
      s.lane = l;
      return s;
   endfunction

   // mode table: 4 modes by 16 host slots
   function automatic slot_type slot_lookup(input logic [1:0] mode, input logic [3:0] idx);
      slot_type s;
      s = mk(HREG_RES, LANE_FULL);
      unique case (mode)
         2'd0, 2'd1: begin
            unique case (idx)
               4'd0: s = mk(HREG_PAR, LANE_LOW);
               4'd1: s = mk(HREG_PAR, LANE_HIGH);
               4'd2: s = mk(HREG_PDR, LANE_LOW);
               4'd3: s = mk(HREG_PDR, LANE_HIGH);
               4'd4: s = mk(HREG_EMR, LANE_LOW);
               4'd5: s = mk(HREG_EMR, LANE_HIGH);
               4'd6: s = mk(HREG_ESR, LANE_LOW);
               4'd7: s = mk(HREG_PCR, LANE_LOW);
               default: begin
                  if (mode == 2'd0) begin
                     s = mk(HREG_PIR, LANE_HIGH);
                  end else begin
                     unique case (idx)
                        4'd8:  s = mk(HREG_PIR, LANE_LOW);
                        4'd9:  s = mk(HREG_PIR, LANE_HIGH);
                        4'd10: s = mk(HREG_PCR, LANE_HIGH);
                        4'd11: s = mk(HREG_PARE, LANE_LOW);
                        4'd12: s = mk(HREG_PDR2, LANE_LOW);
                        4'd13: s = mk(HREG_PDR2, LANE_HIGH);
                        default: s = mk(HREG_RES, LANE_FULL);
                     endcase
                  end
               end
            endcase
         end
         2'd3: begin
            unique case (idx)
               4'd0:  s = mk(HREG_PAR, LANE_FULL);
               4'd2:  s = mk(HREG_PDR, LANE_FULL);
               4'd4:  s = mk(HREG_EMR, LANE_FULL);
               4'd6:  s = mk(HREG_ESR, LANE_LOW);
               4'd7:  s = mk(HREG_PCR, LANE_FULL);
               4'd8:  s = mk(HREG_PIR, LANE_FULL);
               4'd11: s = mk(HREG_PARE, LANE_LOW);
               4'd12: s = mk(HREG_PDR2, LANE_FULL);
               default: s = mk(HREG_RES, LANE_FULL);
            endcase
         end
         default: s = mk(HREG_RES, LANE_FULL);
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/dsp_host_parallel_port_dma.sv =====
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    kind, reg_index, write_data, mem_read_data
// rsp_      out        rsp_valid/stall    read_data, mem_request, mem_address,
//                                         mem_write_data, pif_pin, core_reset
//
// One transfer per cycle while req_stall is low: each request is decoded, merged into the register file
// and its result captured in the output register in the cycle it is accepted.
// rsp_valid rises in the cycle after the request transfer.
// Synchronous active-high reset clears all host registers (mask to 0xffff).
// req_stall rises only while a held result waits under rsp_stall.
module dsp_host_parallel_port_dma (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_reg_index,
   input  logic [15:0] req_write_data,
   input  logic [31:0] req_mem_read_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_data,
   output logic [2:0]  rsp_mem_request,
   output logic [23:0] rsp_mem_address,
   output logic [31:0] rsp_mem_write_data,
   output logic        rsp_pif_pin,
   output logic        rsp_core_reset
);

   // host register state
   logic [15:0] addr_low_ff, addr_low_in;
   logic [7:0]  addr_ext_ff, addr_ext_in;
   logic [15:0] data_high_ff, data_high_in;
   logic [15:0] data_low_ff, data_low_in;
   logic [15:0] hint_ff, hint_in;
   logic [15:0] ctrl_ff, ctrl_in;
   logic [15:0] emr_ff, emr_in;
   logic [7:0]  esr_ff, esr_in;
   logic        load_wait_ff, load_wait_in;
   logic        load_long_ff, load_long_in;

   // result register
   logic        rsp_valid_ff;
   logic [15:0] read_data_ff, read_data_in;
   logic [2:0]  mem_req_ff, mem_req_in;
   logic [23:0] mem_addr_ff, mem_addr_in;
   logic [31:0] mem_wdata_ff, mem_wdata_in;
   logic        pin_ff, pin_in;
   logic        pulse_ff, pulse_in;

   logic                 req_accept;
   hppdma_pkg::slot_type slot;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // decode and execute one host access
   always_comb begin
      logic [15:0] keep;
      logic [15:0] wd;
      logic [15:0] rval;
      logic [15:0] ctrl_new;
      logic [23:0] full_addr;
      logic        upper;
      logic        do_load;
      logic        do_auto;

      slot = hppdma_pkg::slot_lookup({ctrl_ff[hppdma_pkg::CtlPort16],
                                      ctrl_ff[hppdma_pkg::CtlMap]}, req_reg_index);
      addr_low_in  = addr_low_ff;
      addr_ext_in  = addr_ext_ff;
      data_high_in = data_high_ff;
      data_low_in  = data_low_ff;
      hint_in      = hint_ff;
      ctrl_in      = ctrl_ff;
      emr_in       = emr_ff;
      esr_in       = esr_ff;
      load_wait_in = load_wait_ff;
      load_long_in = load_long_ff;
      read_data_in = 16'h0000;
      mem_req_in   = hppdma_pkg::MEM_NONE;
      mem_addr_in  = 24'h000000;
      mem_wdata_in = 32'h00000000;
      pulse_in     = 1'b0;
      rval         = 16'h0000;
      ctrl_new     = 16'h0000;
      full_addr    = 24'h000000;
      do_load      = 1'b0;
      do_auto      = 1'b0;

      // lane mask and aligned write data
      upper = (slot.lane != hppdma_pkg::LANE_LOW);
      case (slot.lane)
         hppdma_pkg::LANE_LOW: begin
            keep = 16'hff00;
            wd   = {8'h00, req_write_data[7:0]};
         end
         hppdma_pkg::LANE_HIGH: begin
            keep = 16'h00ff;
            wd   = {req_write_data[7:0], 8'h00};
         end
         default: begin
            keep = 16'h0000;
            wd   = req_write_data;
         end
      endcase

      unique case (hppdma_pkg::kind_type'(req_kind))
         hppdma_pkg::KIND_WRITE: begin
            unique case (slot.hreg)
               hppdma_pkg::HREG_PAR: begin
                  addr_low_in = (addr_low_ff & keep) | wd;
                  do_load     = upper;
               end
               hppdma_pkg::HREG_PARE: addr_ext_in = (addr_ext_ff & keep[7:0]) | wd[7:0];
               hppdma_pkg::HREG_PDR: begin
                  data_high_in = (data_high_ff & keep) | wd;
                  if (upper) begin
                     // store the data word, clear data full, then step the address
                     if (ctrl_ff[hppdma_pkg::CtlDma]) begin
                        full_addr = {addr_ext_ff, addr_low_ff};
                        if (ctrl_ff[hppdma_pkg::CtlDma32]) begin
                           mem_req_in   = hppdma_pkg::MEM_WRITE_LONG;
                           mem_addr_in  = full_addr & hppdma_pkg::AlignLong;
                           mem_wdata_in = {data_high_in, data_low_ff};
                        end else begin
                           mem_req_in   = hppdma_pkg::MEM_WRITE_WORD;
                           mem_addr_in  = full_addr & hppdma_pkg::AlignWord;
                           mem_wdata_in = {16'h0000, data_high_in};
                        end
                        ctrl_in[hppdma_pkg::CtlPdf] = 1'b0;
                     end
                     do_auto = 1'b1;
                  end
               end
               hppdma_pkg::HREG_PDR2: data_low_in = (data_low_ff & keep) | wd;
               hppdma_pkg::HREG_EMR:  emr_in = (emr_ff & keep) | wd;
               hppdma_pkg::HREG_ESR:  esr_in = (esr_ff & keep[7:0]) | wd[7:0];
               hppdma_pkg::HREG_PCR: begin
                  ctrl_new = (ctrl_ff & (keep | hppdma_pkg::CtlHostKeep))
                           | (wd & ~(keep | hppdma_pkg::CtlHostKeep));
                  ctrl_in  = ctrl_new;
                  // rising core reset bit
                  if (!ctrl_ff[hppdma_pkg::CtlReset] && ctrl_new[hppdma_pkg::CtlReset]) begin
                     pulse_in = 1'b1;
                     ctrl_in  = hppdma_pkg::CtlAfterReset;
                     esr_in   = 8'h00;
                     emr_in   = hppdma_pkg::EmrReset;
                  end
               end
               hppdma_pkg::HREG_PIR: begin
                  hint_in = (hint_ff & keep) | wd;
                  if (upper) begin
                     ctrl_in[hppdma_pkg::CtlPif] = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         hppdma_pkg::KIND_READ: begin
            unique case (slot.hreg)
               hppdma_pkg::HREG_PAR:  rval = addr_low_ff | 16'h0001;
               hppdma_pkg::HREG_PARE: rval = {8'h00, addr_ext_ff};
               hppdma_pkg::HREG_PDR: begin
                  rval    = data_high_ff;
                  do_auto = (slot.lane != hppdma_pkg::LANE_HIGH);
                  do_load = (slot.lane == hppdma_pkg::LANE_FULL);
               end
               hppdma_pkg::HREG_PDR2: rval = data_low_ff;
               hppdma_pkg::HREG_EMR:  rval = emr_ff;
               hppdma_pkg::HREG_ESR:  rval = {8'h00, esr_ff};
               hppdma_pkg::HREG_PCR:  rval = ctrl_ff;
               hppdma_pkg::HREG_PIR: begin
                  rval = hint_ff;
                  if (slot.lane == hppdma_pkg::LANE_FULL) begin
                     ctrl_in[hppdma_pkg::CtlPif] = 1'b0;
                  end
               end
               default: rval = hppdma_pkg::ReadReserved;
            endcase
            // shift the selected lane down
            if (slot.hreg == hppdma_pkg::HREG_RES) begin
               read_data_in = rval;
            end else begin
               case (slot.lane)
                  hppdma_pkg::LANE_HIGH: read_data_in = {8'h00, rval[15:8]};
                  hppdma_pkg::LANE_LOW:  read_data_in = {8'h00, rval[7:0]};
                  default:               read_data_in = rval;
               endcase
            end
         end
         hppdma_pkg::KIND_REPLY: begin
            // fill the data register from a waiting load
            if (load_wait_ff) begin
               if (load_long_ff) begin
                  data_high_in = req_mem_read_data[31:16];
                  data_low_in  = req_mem_read_data[15:0];
               end else begin
                  data_high_in = req_mem_read_data[15:0];
               end
               load_wait_in = 1'b0;
               ctrl_in[hppdma_pkg::CtlPdf] = 1'b1;
            end
         end
         default: ;
      endcase

      // address auto-increment, carry into the extension
      if (do_auto && ctrl_ff[hppdma_pkg::CtlAuto]) begin
         {addr_ext_in, addr_low_in} = {addr_ext_in, addr_low_in}
            + (ctrl_ff[hppdma_pkg::CtlDma32] ? 24'd4 : 24'd2);
      end

      // load from the updated address
      if (do_load && ctrl_ff[hppdma_pkg::CtlDma]) begin
         full_addr    = {addr_ext_in, addr_low_in};
         load_wait_in = 1'b1;
         load_long_in = ctrl_ff[hppdma_pkg::CtlDma32];
         if (ctrl_ff[hppdma_pkg::CtlDma32]) begin
            mem_req_in  = hppdma_pkg::MEM_READ_LONG;
            mem_addr_in = full_addr & hppdma_pkg::AlignLong;
         end else begin
            mem_req_in  = hppdma_pkg::MEM_READ_WORD;
            mem_addr_in = full_addr & hppdma_pkg::AlignWord;
         end
         mem_wdata_in = 32'h00000000;
      end

      pin_in = ctrl_in[hppdma_pkg::CtlPif] && ctrl_in[hppdma_pkg::CtlEni];
   end

   // advance register state on each request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_low_ff  <= 16'h0000;
         addr_ext_ff  <= 8'h00;
         data_high_ff <= 16'h0000;
         data_low_ff  <= 16'h0000;
         hint_ff      <= 16'h0000;
         ctrl_ff      <= 16'h0000;
         emr_ff       <= hppdma_pkg::EmrReset;
         esr_ff       <= 8'h00;
         load_wait_ff <= 1'b0;
         load_long_ff <= 1'b0;
      end else if (req_accept) begin
         addr_low_ff  <= addr_low_in;
         addr_ext_ff  <= addr_ext_in;
         data_high_ff <= data_high_in;
         data_low_ff  <= data_low_in;
         hint_ff      <= hint_in;
         ctrl_ff      <= ctrl_in;
         emr_ff       <= emr_in;
         esr_ff       <= esr_in;
         load_wait_ff <= load_wait_in;
         load_long_ff <= load_long_in;
      end
   end

   // hold the result until the response transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         read_data_ff <= read_data_in;
         mem_req_ff   <= mem_req_in;
         mem_addr_ff  <= mem_addr_in;
         mem_wdata_ff <= mem_wdata_in;
         pin_ff       <= pin_in;
         pulse_ff     <= pulse_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = read_data_ff;
   assign rsp_mem_request    = mem_req_ff;
   assign rsp_mem_address    = mem_addr_ff;
   assign rsp_mem_write_data = mem_wdata_ff;
   assign rsp_pif_pin        = pin_ff;
   assign rsp_core_reset     = pulse_ff;

endmodule

// ===== sim/dsp_host_parallel_port_dma_tb.sv =====
module dsp_host_parallel_port_dma_tb;

   localparam int unsigned CycleLimit = 400000;

   // host slot numbers; their meaning depends on the map mode
   localparam logic [3:0] SlotAddr      = 4'd0;
   localparam logic [3:0] SlotAddrHi    = 4'd1;
   localparam logic [3:0] SlotData      = 4'd2;
   localparam logic [3:0] SlotMask      = 4'd4;
   localparam logic [3:0] SlotControl   = 4'd7;
   localparam logic [3:0] SlotIntr      = 4'd8;
   localparam logic [3:0] SlotControlHi = 4'd10;
   localparam logic [3:0] SlotAddrExt   = 4'd11;
   localparam logic [3:0] SlotData2     = 4'd12;
   localparam logic [3:0] SlotUnused    = 4'd15;

   // control word masks
   localparam logic [15:0] ResetMask  = 16'd1 << hppdma_pkg::CtlReset;
   localparam logic [15:0] MapMask    = 16'd1 << hppdma_pkg::CtlMap;
   localparam logic [15:0] EniMask    = 16'd1 << hppdma_pkg::CtlEni;
   localparam logic [15:0] DmaMask    = 16'd1 << hppdma_pkg::CtlDma;
   localparam logic [15:0] AutoMask   = 16'd1 << hppdma_pkg::CtlAuto;
   localparam logic [15:0] PdfMask    = 16'd1 << hppdma_pkg::CtlPdf;
   localparam logic [15:0] PifMask    = 16'd1 << hppdma_pkg::CtlPif;
   localparam logic [15:0] Dma32Mask  = 16'd1 << hppdma_pkg::CtlDma32;
   localparam logic [15:0] Port16Mask = 16'd1 << hppdma_pkg::CtlPort16;

   typedef struct packed {
      logic [15:0]             read_data;
      hppdma_pkg::mem_req_type mem_request;
      logic [23:0]             mem_address;
      logic [31:0]             mem_write_data;
      logic                    pif_pin;
      logic                    core_reset;
   } port_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = 2'd0;
   logic [3:0]  req_reg_index = 4'd0;
   logic [15:0] req_write_data = 16'h0000;
   logic [31:0] req_mem_read_data = 32'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_read_data;
   logic [2:0]  rsp_mem_request;
   logic [23:0] rsp_mem_address;
   logic [31:0] rsp_mem_write_data;
   logic        rsp_pif_pin;
   logic        rsp_core_reset;

   // port model state
   logic [15:0] port_addr_lo = 16'h0000;
   logic [7:0]  port_addr_ext = 8'h00;
   logic [15:0] port_data_hi = 16'h0000;
   logic [15:0] port_data_lo = 16'h0000;
   logic [15:0] port_int_word = 16'h0000;
   logic [15:0] port_ctl = 16'h0000;
   logic [15:0] port_err_mask = hppdma_pkg::EmrReset;
   logic [7:0]  port_err_stat = 8'h00;
   logic        load_pending = 1'b0;
   logic        load_long = 1'b0;

   // memory request and reset pulse raised during one transfer
   logic                    step_pulse;
   hppdma_pkg::mem_req_type step_req;
   logic [23:0]             step_addr;
   logic [31:0]             step_wdata;

   port_result_type expected_results[$];

   int unsigned send_idle_pct = 27;
   int unsigned recv_stall_pct = 87;
   int unsigned n_errors = 0;
   int unsigned n_sent = 0;
   int unsigned n_checked = 0;
   int unsigned n_dma = 0;
   int unsigned n_core_resets = 0;
   int unsigned cycle_count = 0;

   dsp_host_parallel_port_dma DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_reg_index      (req_reg_index),
      .req_write_data     (req_write_data),
      .req_mem_read_data  (req_mem_read_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_mem_request    (rsp_mem_request),
      .rsp_mem_address    (rsp_mem_address),
      .rsp_mem_write_data (rsp_mem_write_data),
      .rsp_pif_pin        (rsp_pif_pin),
      .rsp_core_reset     (rsp_core_reset)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- port model

   // map a host slot to register and byte lane for the current mode
   function automatic hppdma_pkg::slot_type route_slot(input logic [1:0] mode,
                                                       input logic [3:0] idx);
      hppdma_pkg::slot_type s;
      s = {hppdma_pkg::HREG_RES, hppdma_pkg::LANE_FULL};
      if (mode == 2'd3) begin
         case (idx)
            4'd0:  s = {hppdma_pkg::HREG_PAR, hppdma_pkg::LANE_FULL};
            4'd2:  s = {hppdma_pkg::HREG_PDR, hppdma_pkg::LANE_FULL};
            4'd4:  s = {hppdma_pkg::HREG_EMR, hppdma_pkg::LANE_FULL};
            4'd6:  s = {hppdma_pkg::HREG_ESR, hppdma_pkg::LANE_LOW};
            4'd7:  s = {hppdma_pkg::HREG_PCR, hppdma_pkg::LANE_FULL};
            4'd8:  s = {hppdma_pkg::HREG_PIR, hppdma_pkg::LANE_FULL};
            4'd11: s = {hppdma_pkg::HREG_PARE, hppdma_pkg::LANE_LOW};
            4'd12: s = {hppdma_pkg::HREG_PDR2, hppdma_pkg::LANE_FULL};
            default: s = {hppdma_pkg::HREG_RES, hppdma_pkg::LANE_FULL};
         endcase
      end else if (mode != 2'd2) begin
         case (idx)
            4'd0: s = {hppdma_pkg::HREG_PAR, hppdma_pkg::LANE_LOW};
            4'd1: s = {hppdma_pkg::HREG_PAR, hppdma_pkg::LANE_HIGH};
            4'd2: s = {hppdma_pkg::HREG_PDR, hppdma_pkg::LANE_LOW};
            4'd3: s = {hppdma_pkg::HREG_PDR, hppdma_pkg::LANE_HIGH};
            4'd4: s = {hppdma_pkg::HREG_EMR, hppdma_pkg::LANE_LOW};
            4'd5: s = {hppdma_pkg::HREG_EMR, hppdma_pkg::LANE_HIGH};
            4'd6: s = {hppdma_pkg::HREG_ESR, hppdma_pkg::LANE_LOW};
            4'd7: s = {hppdma_pkg::HREG_PCR, hppdma_pkg::LANE_LOW};
            default: begin
               if (mode == 2'd0) begin
                  s = {hppdma_pkg::HREG_PIR, hppdma_pkg::LANE_HIGH};
               end else begin
                  case (idx)
                     4'd8:  s = {hppdma_pkg::HREG_PIR, hppdma_pkg::LANE_LOW};
                     4'd9:  s = {hppdma_pkg::HREG_PIR, hppdma_pkg::LANE_HIGH};
                     4'd10: s = {hppdma_pkg::HREG_PCR, hppdma_pkg::LANE_HIGH};
                     4'd11: s = {hppdma_pkg::HREG_PARE, hppdma_pkg::LANE_LOW};
                     4'd12: s = {hppdma_pkg::HREG_PDR2, hppdma_pkg::LANE_LOW};
                     4'd13: s = {hppdma_pkg::HREG_PDR2, hppdma_pkg::LANE_HIGH};
                     default: s = {hppdma_pkg::HREG_RES, hppdma_pkg::LANE_FULL};
                  endcase
               end
            end
         endcase
      end
      return s;
   endfunction

   function automatic logic [1:0] current_mode();
      return {port_ctl[hppdma_pkg::CtlPort16], port_ctl[hppdma_pkg::CtlMap]};
   endfunction

   // update control; a rising reset bit pulses and clears registers
   function automatic void apply_control(input logic [15:0] v);
      logic rose;
      rose = !port_ctl[hppdma_pkg::CtlReset] && v[hppdma_pkg::CtlReset];
      port_ctl = v;
      if (rose) begin
         step_pulse = 1'b1;
         port_ctl = hppdma_pkg::CtlAfterReset;
         port_err_stat = 8'h00;
         port_err_mask = hppdma_pkg::EmrReset;
      end
   endfunction

   // step the DMA address by 2 or 4, carrying into the extension
   function automatic void advance_address();
      logic [16:0] sum;
      if (port_ctl[hppdma_pkg::CtlAuto]) begin
         sum = {1'b0, port_addr_lo} + (port_ctl[hppdma_pkg::CtlDma32] ? 17'd4 : 17'd2);
         port_addr_lo = sum[15:0];
         if (sum[16]) begin
            port_addr_ext = port_addr_ext + 8'd1;
         end
      end
   endfunction

   function automatic void issue_load();
      if (port_ctl[hppdma_pkg::CtlDma]) begin
         load_pending = 1'b1;
         load_long = port_ctl[hppdma_pkg::CtlDma32];
         step_wdata = 32'h0;
         if (load_long) begin
            step_req = hppdma_pkg::MEM_READ_LONG;
            step_addr = {port_addr_ext, port_addr_lo} & hppdma_pkg::AlignLong;
         end else begin
            step_req = hppdma_pkg::MEM_READ_WORD;
            step_addr = {port_addr_ext, port_addr_lo} & hppdma_pkg::AlignWord;
         end
      end
   endfunction

   function automatic void issue_store();
      if (port_ctl[hppdma_pkg::CtlDma]) begin
         if (port_ctl[hppdma_pkg::CtlDma32]) begin
            step_req = hppdma_pkg::MEM_WRITE_LONG;
            step_addr = {port_addr_ext, port_addr_lo} & hppdma_pkg::AlignLong;
            step_wdata = {port_data_hi, port_data_lo};
         end else begin
            step_req = hppdma_pkg::MEM_WRITE_WORD;
            step_addr = {port_addr_ext, port_addr_lo} & hppdma_pkg::AlignWord;
            step_wdata = {16'h0000, port_data_hi};
         end
         apply_control(port_ctl & ~PdfMask);
      end
   endfunction

   // merge a host write into the selected lane and run its side effects
   function automatic void apply_host_write(input hppdma_pkg::slot_type s,
                                            input logic [15:0] wd);
      logic [15:0] keep;
      logic [15:0] d;
      logic        upper;
      upper = (s.lane != hppdma_pkg::LANE_LOW);
      case (s.lane)
         hppdma_pkg::LANE_LOW: begin
            keep = 16'hff00;
            d = {8'h00, wd[7:0]};
         end
         hppdma_pkg::LANE_HIGH: begin
            keep = 16'h00ff;
            d = {wd[7:0], 8'h00};
         end
         default: begin
            keep = 16'h0000;
            d = wd;
         end
      endcase
      case (s.hreg)
         hppdma_pkg::HREG_PAR: begin
            port_addr_lo = (port_addr_lo & keep) | d;
            if (upper) begin
               issue_load();
            end
         end
         hppdma_pkg::HREG_PARE: port_addr_ext = (port_addr_ext & keep[7:0]) | d[7:0];
         hppdma_pkg::HREG_PDR: begin
            port_data_hi = (port_data_hi & keep) | d;
            if (upper) begin
               issue_store();
               advance_address();
            end
         end
         hppdma_pkg::HREG_PDR2: port_data_lo = (port_data_lo & keep) | d;
         hppdma_pkg::HREG_EMR:  port_err_mask = (port_err_mask & keep) | d;
         hppdma_pkg::HREG_ESR:  port_err_stat = (port_err_stat & keep[7:0]) | d[7:0];
         hppdma_pkg::HREG_PCR: begin
            keep = keep | hppdma_pkg::CtlHostKeep;
            apply_control((port_ctl & keep) | (d & ~keep));
         end
         hppdma_pkg::HREG_PIR: begin
            port_int_word = (port_int_word & keep) | d;
            if (upper) begin
               apply_control(port_ctl | PifMask);
            end
         end
         default: ;
      endcase
   endfunction

   // value of a host read; reserved slots read all ones on the full lane
   function automatic logic [15:0] apply_host_read(input hppdma_pkg::slot_type s);
      logic [15:0] r;
      case (s.hreg)
         hppdma_pkg::HREG_PAR:  r = port_addr_lo | 16'h0001;
         hppdma_pkg::HREG_PARE: r = {8'h00, port_addr_ext};
         hppdma_pkg::HREG_PDR: begin
            r = port_data_hi;
            if (s.lane != hppdma_pkg::LANE_HIGH) begin
               advance_address();
            end
            if (s.lane == hppdma_pkg::LANE_FULL) begin
               issue_load();
            end
         end
         hppdma_pkg::HREG_PDR2: r = port_data_lo;
         hppdma_pkg::HREG_EMR:  r = port_err_mask;
         hppdma_pkg::HREG_ESR:  r = {8'h00, port_err_stat};
         hppdma_pkg::HREG_PCR:  r = port_ctl;
         hppdma_pkg::HREG_PIR: begin
            if (s.lane == hppdma_pkg::LANE_FULL) begin
               apply_control(port_ctl & ~PifMask);
            end
            r = port_int_word;
         end
         default: r = hppdma_pkg::ReadReserved;
      endcase
      case (s.lane)
         hppdma_pkg::LANE_HIGH: return {8'h00, r[15:8]};
         hppdma_pkg::LANE_LOW:  return {8'h00, r[7:0]};
         default:               return r;
      endcase
   endfunction

   // advance the port model by one transfer and return its result
   function automatic port_result_type predict_transfer(input hppdma_pkg::kind_type k,
                                                        input logic [3:0] idx,
                                                        input logic [15:0] wd,
                                                        input logic [31:0] md);
      port_result_type      res;
      hppdma_pkg::slot_type s;
      s = route_slot(current_mode(), idx);
      step_pulse = 1'b0;
      step_req = hppdma_pkg::MEM_NONE;
      step_addr = 24'h0;
      step_wdata = 32'h0;
      res.read_data = 16'h0000;
      case (k)
         hppdma_pkg::KIND_WRITE: apply_host_write(s, wd);
         hppdma_pkg::KIND_READ:  res.read_data = apply_host_read(s);
         hppdma_pkg::KIND_REPLY: begin
            if (load_pending) begin
               if (load_long) begin
                  port_data_hi = md[31:16];
                  port_data_lo = md[15:0];
               end else begin
                  port_data_hi = md[15:0];
               end
               load_pending = 1'b0;
               apply_control(port_ctl | PdfMask);
            end
         end
         default: ;
      endcase
      res.mem_request = step_req;
      res.mem_address = step_addr;
      res.mem_write_data = step_wdata;
      res.pif_pin = port_ctl[hppdma_pkg::CtlPif] & port_ctl[hppdma_pkg::CtlEni];
      res.core_reset = step_pulse;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // drive one transfer, hold it until accepted, then record its result
   task automatic send_item(input hppdma_pkg::kind_type k, input logic [3:0] idx,
                            input logic [15:0] wd, input logic [31:0] md);
      port_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_reg_index <= idx;
      req_write_data <= wd;
      req_mem_read_data <= md;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      res = predict_transfer(k, idx, wd, md);
      expected_results.push_back(res);
      n_sent++;
      if (res.mem_request != hppdma_pkg::MEM_NONE) begin
         n_dma++;
      end
      if (res.core_reset) begin
         n_core_resets++;
      end
   endtask

   task automatic test_reset_values();
      send_item(hppdma_pkg::KIND_READ, SlotMask, 16'h0000, 32'h0);
      send_item(hppdma_pkg::KIND_READ, SlotAddr, 16'h0000, 32'h0);
   endtask

   // long DMA at the top of memory, address wrap, reply handling
   task automatic test_dma_long_path();
      send_item(hppdma_pkg::KIND_WRITE, SlotControl, MapMask | DmaMask | AutoMask, 32'h0);
      send_item(hppdma_pkg::KIND_WRITE, SlotControlHi, (Dma32Mask | Port16Mask) >> 8,
                32'h0);
      send_item(hppdma_pkg::KIND_WRITE, SlotAddrExt, 16'h00ff, 32'h0);
      send_item(hppdma_pkg::KIND_WRITE, SlotAddr, 16'hfffe, 32'h0);
      // second load replaces the waiting one
      send_item(hppdma_pkg::KIND_WRITE, SlotAddr, 16'hfffc, 32'h0);
      send_item(hppdma_pkg::KIND_REPLY, SlotAddr, 16'h0000, 32'hffff_ffff);
      send_item(hppdma_pkg::KIND_READ, SlotData2, 16'h0000, 32'h0);
      // store, then auto-increment carries out of the extension
      send_item(hppdma_pkg::KIND_WRITE, SlotData, 16'hffff, 32'h0);
      send_item(hppdma_pkg::KIND_READ, SlotData, 16'h0000, 32'h0);
      send_item(hppdma_pkg::KIND_REPLY, SlotAddr, 16'h0000, 32'h0000_0000);
      // reply with nothing waiting
      send_item(hppdma_pkg::KIND_REPLY, SlotAddr, 16'h0000, 32'h1234_5678);
   endtask

   task automatic test_interrupt_flag();
      send_item(hppdma_pkg::KIND_WRITE, SlotIntr, 16'h0000, 32'h0);
      send_item(hppdma_pkg::KIND_WRITE, SlotControl,
                MapMask | EniMask | AutoMask | Dma32Mask | Port16Mask, 32'h0);
      send_item(hppdma_pkg::KIND_READ, SlotIntr, 16'h0000, 32'h0);
   endtask

   task automatic test_reserved_and_idle();
      send_item(hppdma_pkg::KIND_READ, SlotAddrHi, 16'h0000, 32'h0);
      send_item(hppdma_pkg::KIND_WRITE, SlotUnused, 16'hffff, 32'h0);
      send_item(hppdma_pkg::KIND_IDLE, SlotAddr, 16'hffff, 32'hffff_ffff);
   endtask

   task automatic test_core_reset();
      send_item(hppdma_pkg::KIND_WRITE, SlotControl,
                ResetMask | MapMask | EniMask | Port16Mask, 32'h0);
      send_item(hppdma_pkg::KIND_READ, SlotControl, 16'h0000, 32'h0);
      send_item(hppdma_pkg::KIND_WRITE, SlotControl, 16'h0000, 32'h0);
   endtask

   // rarely pulse core reset, and never enter the mode that locks the port
   function automatic logic [15:0] shape_control_write(input hppdma_pkg::lane_type lane,
                                                       input logic [15:0] wd);
      logic [15:0] v;
      v = wd;
      if (lane != hppdma_pkg::LANE_HIGH && $urandom_range(7) != 0) begin
         v[hppdma_pkg::CtlReset] = 1'b0;
      end
      case (lane)
         hppdma_pkg::LANE_LOW: begin
            if (port_ctl[hppdma_pkg::CtlPort16]) begin
               v[hppdma_pkg::CtlMap] = 1'b1;
            end
         end
         hppdma_pkg::LANE_HIGH: begin
            if (!port_ctl[hppdma_pkg::CtlMap]) begin
               v[hppdma_pkg::CtlPort16 - 8] = 1'b0;
            end
         end
         default: begin
            if (v[hppdma_pkg::CtlPort16]) begin
               v[hppdma_pkg::CtlMap] = 1'b1;
            end
         end
      endcase
      return v;
   endfunction

   // random host traffic
   task automatic test_random_traffic(input int unsigned count);
      int unsigned          pick;
      hppdma_pkg::kind_type k;
      logic [3:0]           idx;
      logic [15:0]          wd;
      logic [31:0]          md;
      hppdma_pkg::slot_type s;
      for (int unsigned i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            k = hppdma_pkg::KIND_WRITE;
         end else if (pick < 75) begin
            k = hppdma_pkg::KIND_READ;
         end else if (pick < 95) begin
            k = hppdma_pkg::KIND_REPLY;
         end else begin
            k = hppdma_pkg::KIND_IDLE;
         end
         idx = 4'($urandom_range(15));
         wd = 16'($urandom_range(16'hffff));
         md = $urandom;
         s = route_slot(current_mode(), idx);
         if (k == hppdma_pkg::KIND_WRITE && s.hreg == hppdma_pkg::HREG_PCR) begin
            wd = shape_control_write(s.lane, wd);
         end
         send_item(k, idx, wd, md);
      end
   endtask

   // walk into the mode where every slot is reserved; the port stays there
   task automatic test_illegal_mode();
      if (!port_ctl[hppdma_pkg::CtlPort16]) begin
         send_item(hppdma_pkg::KIND_WRITE, SlotControl, MapMask, 32'h0);
         send_item(hppdma_pkg::KIND_WRITE, SlotControlHi, Port16Mask >> 8, 32'h0);
      end
      send_item(hppdma_pkg::KIND_WRITE, SlotControl, Port16Mask, 32'h0);
      send_item(hppdma_pkg::KIND_READ, SlotControl, 16'h0000, 32'h0);
      send_item(hppdma_pkg::KIND_WRITE, SlotAddr, 16'hffff, 32'h0);
      send_item(hppdma_pkg::KIND_READ, SlotAddr, 16'h0000, 32'h0);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      n_errors++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                   n_checked, name, got, want));
      end
   endtask

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      port_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            want = expected_results.pop_front();
            check_field("read_data", 32'(rsp_read_data), 32'(want.read_data));
            check_field("mem_request", 32'(rsp_mem_request), 32'(want.mem_request));
            check_field("mem_address", 32'(rsp_mem_address), 32'(want.mem_address));
            check_field("mem_write_data", rsp_mem_write_data, want.mem_write_data);
            check_field("pif_pin", 32'(rsp_pif_pin), 32'(want.pif_pin));
            check_field("core_reset", 32'(rsp_core_reset), 32'(want.core_reset));
            n_checked++;
         end
      end
   end

   // random back-pressure on the result side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_dma_long_path();
      test_interrupt_flag();
      test_reserved_and_idle();
      test_core_reset();
      test_random_traffic(670);

      send_idle_pct = 87;
      recv_stall_pct = 27;
      test_random_traffic(670);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_traffic(670);
      test_illegal_mode();

      // drain outstanding results before reporting
      req_valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);

      $display("Sent %0d host transfers under three stall mixes: %0d DMA requests,",
               n_sent, n_dma);
      $display("%0d core reset pulses, %0d results checked, %0d mismatches.",
               n_core_resets, n_checked, n_errors);
      if (n_errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
